FILE: src/assert_macros.svh
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/spp_pkg.sv
// Package for the sweep-and-prune pair finder: widths, constants, types.
// No dependencies.
package spp_pkg;
   localparam int ActiveDepth = 32;
   localparam int IdxW = $clog2(ActiveDepth);
   localparam int CntW = $clog2(ActiveDepth + 1);
   localparam int IdW = 16;
   localparam int PosW = 32;
   localparam int CutW = 31;
   localparam int ExtW = 34;
   localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

   typedef struct packed {
      logic [IdW-1:0]  particle_id;
      logic [PosW-1:0] position;
      logic            start_sweep;
   } req_type;

   typedef struct packed {
      logic [IdW-1:0] low_id;
      logic [IdW-1:0] high_id;
      logic           is_pair;
      logic           last;
      logic           overflow;
      logic           order_error;
   } rsp_type;

   // classified transaction passed from front to back
   typedef struct packed {
      logic [IdW-1:0]  particle_id;
      logic [PosW-1:0] position;
      logic            start_sweep;
      logic            order_error;
   } job_type;
endpackage

FILE: src/spp_if.sv
// Valid/ready channel interfaces, each carrying one packed payload.
// Depends on spp_pkg for payload types.
interface spp_req_if;
   logic               valid;
   logic               ready;
   spp_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spp_rsp_if;
   logic               valid;
   logic               ready;
   spp_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/sweep_prune_pair_finder_top.sv
// Sweep-and-prune pair finder: for each particle (ascending position) it walks
// the active list and reports candidate pairs, then a closing transaction.
// The back end reads the N active entries one after another through the single
// read port of the active-list RAM, emitting one transaction per pair, and it
// holds while rsp is not ready. A two-entry queue lets the next particle be
// accepted while the current one is swept.
module sweep_prune_pair_finder_top (
   input  logic                     clock,
   input  logic                     reset,
   spp_req_if.sink                  req,
   spp_rsp_if.source                rsp,
   input  logic                     csr_wr_en,
   input  logic [spp_pkg::CutW-1:0] csr_wr_data
);
   logic [spp_pkg::CutW-1:0] cutoff_ff;
   logic                     job_valid, job_ready;
   spp_pkg::job_type         job_data;

   always_ff @(posedge clock) begin
      if (reset) cutoff_ff <= '0;
      else if (csr_wr_en) cutoff_ff <= csr_wr_data;
   end

   spp_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_data(req.data), .job_valid, .job_ready, .job_data);

   spp_back u_back (
      .clock, .reset, .cutoff(cutoff_ff), .job_valid, .job_ready, .job_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule

FILE: src/spp_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module spp_ram #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: src/spp_front.sv
// Front end: accepts particles, tracks previous position, flags order errors,
// and queues classified jobs in a two-entry FIFO. Depends on spp_pkg.
module spp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  spp_pkg::req_type  in_data,
   output logic              job_valid,
   input  logic              job_ready,
   output spp_pkg::job_type  job_data
);
   logic [spp_pkg::PosW-1:0] prev_ff, prev_in;
   spp_pkg::job_type         q_ff [2];
   logic                     wp_ff, rp_ff;
   logic [1:0]               cnt_ff;
   logic                     push, pop;
   spp_pkg::job_type         job_in;
   logic [spp_pkg::PosW-1:0] base;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job_data = q_ff[rp_ff];

   always_comb begin
      base = in_data.start_sweep ? spp_pkg::PosMin : prev_ff;
      job_in.particle_id = in_data.particle_id;
      job_in.position = in_data.position;
      job_in.start_sweep = in_data.start_sweep;
      job_in.order_error = $signed(in_data.position) < $signed(base);
      prev_in = push ? in_data.position : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= job_in;
      end
      if (reset) begin
         prev_ff <= spp_pkg::PosMin;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         prev_ff <= prev_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: src/spp_back.sv
// Back end: walks the active list in RAM, emits pairs, compacts survivors, appends the
// particle if it fits, emits the closing transaction. Depends on spp_pkg, spp_ram.
module spp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [spp_pkg::CutW-1:0] cutoff,
   input  logic                     job_valid,
   output logic                     job_ready,
   input  spp_pkg::job_type         job_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output spp_pkg::rsp_type         out_data
);
   typedef enum logic [2:0] {IDLE, READ, CHECK, EMIT, CLOSE} state_type;

   state_type                 state_ff;
   spp_pkg::job_type          job_ff;
   logic [spp_pkg::CntW-1:0]  count_ff, rd_ff, keep_ff;
   spp_pkg::rsp_type          out_ff;
   logic [spp_pkg::IdW-1:0]   rid;
   logic [spp_pkg::PosW-1:0]  rpos;
   logic                      wr_en;
   logic [spp_pkg::IdxW-1:0]  wr_addr;
   logic [spp_pkg::IdW-1:0]   wr_id;
   logic [spp_pkg::PosW-1:0]  wr_pos;
   logic signed [spp_pkg::ExtW-1:0] lhs, rhs;
   logic                      hit;
   logic                      room;

   spp_ram #(.Width(spp_pkg::IdW), .Depth(spp_pkg::ActiveDepth)) u_ids (
      .clock, .wr_en, .wr_addr, .wr_data(wr_id),
      .rd_addr(rd_ff[spp_pkg::IdxW-1:0]), .rd_data(rid));
   spp_ram #(.Width(spp_pkg::PosW), .Depth(spp_pkg::ActiveDepth)) u_pos (
      .clock, .wr_en, .wr_addr, .wr_data(wr_pos),
      .rd_addr(rd_ff[spp_pkg::IdxW-1:0]), .rd_data(rpos));

   assign job_ready = (state_ff == IDLE);
   assign out_data = out_ff;

   always_comb begin
      lhs = $signed({{2{rpos[spp_pkg::PosW-1]}}, rpos})
          + $signed({3'b000, cutoff});
      rhs = $signed({{2{job_ff.position[spp_pkg::PosW-1]}}, job_ff.position})
          - $signed({3'b000, cutoff});
      hit = (lhs >= rhs);
      room = (keep_ff < spp_pkg::CntW'(spp_pkg::ActiveDepth));
      wr_en = 1'b0;
      wr_addr = keep_ff[spp_pkg::IdxW-1:0];
      wr_id = rid;
      wr_pos = rpos;
      if (state_ff == CHECK && hit) begin
         wr_en = 1'b1;
      end else if (state_ff == CLOSE && !out_valid && room) begin
         wr_en = 1'b1;
         wr_id = job_ff.particle_id;
         wr_pos = job_ff.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  if (job_data.start_sweep) count_ff <= '0;
                  rd_ff <= '0;
                  keep_ff <= '0;
                  state_ff <= READ;
               end
            end
            READ: begin
               if (rd_ff < count_ff) state_ff <= CHECK;
               else state_ff <= CLOSE;
               if (job_ff.start_sweep) state_ff <= CLOSE;
            end
            CHECK: begin
               rd_ff <= rd_ff + spp_pkg::CntW'(1);
               if (hit) begin
                  keep_ff <= keep_ff + spp_pkg::CntW'(1);
                  out_ff.low_id <= (job_ff.particle_id < rid) ? job_ff.particle_id : rid;
                  out_ff.high_id <= (job_ff.particle_id < rid) ? rid : job_ff.particle_id;
                  out_ff.is_pair <= 1'b1;
                  out_ff.last <= 1'b0;
                  out_ff.overflow <= 1'b0;
                  out_ff.order_error <= 1'b0;
                  out_valid <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= READ;
               end
            end
            EMIT: begin
               if (out_ready) begin
                  out_valid <= 1'b0;
                  state_ff <= READ;
               end
            end
            CLOSE: begin
               if (!out_valid) begin
                  if (room) begin
                     count_ff <= keep_ff + spp_pkg::CntW'(1);
                  end else begin
                     count_ff <= keep_ff;
                  end
                  out_ff.low_id <= '0;
                  out_ff.high_id <= '0;
                  out_ff.is_pair <= 1'b0;
                  out_ff.last <= 1'b1;
                  out_ff.overflow <= !room;
                  out_ff.order_error <= job_ff.order_error;
                  out_valid <= 1'b1;
               end else if (out_ready) begin
                  out_valid <= 1'b0;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

FILE: src/spp_checker.sv
// Port-level checker for the pair finder, bound to the top level.
// Depends on assert_macros.svh and spp_pkg.
`include "assert_macros.svh"
module spp_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spp_pkg::rsp_type rsp_data
);
   `CHK_IMPLY(a_pair_not_last, clock, reset, rsp_valid && rsp_data.is_pair, !rsp_data.last && !rsp_data.overflow && !rsp_data.order_error, "pair flagged as last")
   `CHK_IMPLY(a_close_zero, clock, reset, rsp_valid && !rsp_data.is_pair, rsp_data.last && rsp_data.low_id == 0 && rsp_data.high_id == 0, "bad closing")
   `CHK_IMPLY(a_order, clock, reset, rsp_valid && rsp_data.is_pair, rsp_data.low_id <= rsp_data.high_id, "pair ids unordered")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")
endmodule

bind sweep_prune_pair_finder_top spp_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.data));

FILE: test/spp_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side copy is not needed; the RTL interfaces are used directly.
// This file holds the testbench's shared types. Depends on spp_pkg.
package spp_tb_pkg;
   import spp_pkg::*;
   typedef struct {
      logic [IdW-1:0]  id;
      logic [PosW-1:0] pos;
   } entry_type;
endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sweep_prune_pair_finder_top: drives particles,
// predicts pairs and closing transactions, compares in order.
// Depends on spp_pkg, spp_if, spp_tb_pkg and the RTL.
module testbench;
   import spp_pkg::*;
   import spp_tb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CutW-1:0] csr_wr_data = '0;

   spp_req_if req ();
   spp_rsp_if rsp ();

   sweep_prune_pair_finder_top DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [CutW-1:0] cutoff_q = '0;
   entry_type sweep_list[$];
   logic signed [PosW-1:0] prev_pos = PosMin;
   rsp_type pending_rsps[$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic [PosW-1:0] cur_pos = '0;

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   function automatic void predict_sweep(req_type t);
      entry_type kept[$];
      entry_type e;
      rsp_type r;
      logic signed [ExtW-1:0] head;
      logic signed [ExtW-1:0] top;
      logic oerr;
      if (t.start_sweep) begin
         sweep_list.delete();
         prev_pos = PosMin;
      end
      oerr = $signed(t.position) < prev_pos;
      prev_pos = t.position;
      head = $signed(t.position) - $signed({1'b0, cutoff_q});
      foreach (sweep_list[i]) begin
         top = $signed(sweep_list[i].pos) + $signed({1'b0, cutoff_q});
         if (top >= head) begin
            r = '0;
            r.is_pair = 1;
            if (t.particle_id < sweep_list[i].id) begin
               r.low_id = t.particle_id;
               r.high_id = sweep_list[i].id;
            end else begin
               r.low_id = sweep_list[i].id;
               r.high_id = t.particle_id;
            end
            pending_rsps = {pending_rsps, r};
            kept = {kept, sweep_list[i]};
         end
      end
      sweep_list = kept;
      r = '0;
      r.last = 1;
      r.order_error = oerr;
      if (sweep_list.size() >= ActiveDepth) r.overflow = 1;
      else begin
         e.id = t.particle_id;
         e.pos = t.position;
         sweep_list = {sweep_list, e};
      end
      pending_rsps = {pending_rsps, r};
   endfunction

   // valid stays high after acceptance until the next send replaces the data or an idle gap or drain lowers it
   task automatic send_particle(logic [IdW-1:0] id, logic [PosW-1:0] pos, logic start);
      req_type t;
      t.particle_id = id;
      t.position = pos;
      t.start_sweep = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.data <= t;
      do @(posedge clock); while (!req.ready);
      predict_sweep(t);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result check
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp.data);
         end else begin
            exp_r = pending_rsps.pop_front();
            if (rsp.data !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", exp_r, rsp.data);
            end
         end
      end
   end

   task automatic drain;
      req.valid <= 0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_cutoff(logic [CutW-1:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      cutoff_q = v;
   endtask

   task automatic test_extremes;
      write_cutoff('0);
      send_particle(16'd5, PosMin, 1);
      send_particle(16'd5, PosMin, 0);
      send_particle(16'hFFFF, 32'h7FFF_FFFF, 0);
      send_particle(16'd0, 32'h7FFF_FFFF, 0);
      send_particle(16'd9, 32'd0, 0);
      write_cutoff({CutW{1'b1}});
      send_particle(16'd1, PosMin, 1);
      send_particle(16'd2, 32'h7FFF_FFFF, 0);
      send_particle(16'h8000, 32'h7FFF_FFFF, 0);
      send_particle(16'd3, 32'h8000_0001, 0);
   endtask

   task automatic test_overflow;
      write_cutoff(31'h0010_0000);
      for (int i = 0; i < ActiveDepth + 3; i++)
         send_particle(16'(i * 977), 32'(i), i == 0);
   endtask

   task automatic random_sweeps(int n_items);
      int sweep_len;
      sweep_len = 0;
      for (int i = 0; i < n_items; i++) begin
         if (sweep_len == 0) begin
            sweep_len = $urandom_range(40, 2);
            cur_pos = $urandom_range(3) == 0 ? $urandom : -$urandom_range(1 << 20);
            send_particle(16'($urandom), cur_pos, 1);
         end else begin
            if ($urandom_range(19) == 0) cur_pos = $urandom;
            else cur_pos = cur_pos + $urandom_range(1 << 17);
            send_particle(16'($urandom), cur_pos, $urandom_range(49) == 0);
         end
         sweep_len--;
      end
   endtask

   task automatic test_random;
      write_cutoff(31'h0001_0000);
      random_sweeps(65);
      send_idle_pct = 47;
      write_cutoff(31'($urandom));
      random_sweeps(65);
      send_idle_pct = 0;
      stall_pct = 47;
      write_cutoff(31'h0000_8000);
      random_sweeps(65);
      send_idle_pct = 18;
      stall_pct = 18;
      write_cutoff(31'h0004_0000);
      random_sweeps(65);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_overflow();
      test_random();
      drain();
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("[sweep_prune_pair_finder_top] OK");
      else
         $display("[sweep_prune_pair_finder_top] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[sweep_prune_pair_finder_top] ERROR");
      $finish;
   end
endmodule
